FILE: src/frps_pkg.sv
// shared types, widths and constants of the frame rms and peak statistics block
package frps_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int HIGH_W    = SAMPLE_W - 1;
    localparam int SUM_W     = 43;
    localparam int CNT_W     = 13;
    localparam int IDX_W     = 12;
    localparam int RMS_W     = 22;
    localparam int MODE_W    = 2;
    localparam int MAX_FRAME = 4096;

    // shared shift/add unit
    localparam int ACC_W  = 69;             // widest operand: 26 x 43 bit product
    localparam int REM_W  = 28;             // partial remainder of divide and root
    localparam int QUO_W  = 44;             // multiplier bits, quotient, root
    localparam int DVS_W  = 27;             // multiplicand or divisor
    localparam int ROOT_W = QUO_W / 2;
    localparam int STEP_W = $clog2(ACC_W);

    localparam int MUL_STEPS       = SUM_W;
    localparam int DIV_STEPS_WAVE  = SUM_W;
    localparam int DIV_STEPS_SPEC  = ACC_W;
    localparam int SQRT_STEPS      = ROOT_W;

    // 0.8165 squared as a ratio: 8165^2 / 10000^2
    localparam logic [DVS_W-1:0] SPEC_NUM_SQ = 27'd66667225;
    localparam logic [DVS_W-1:0] SPEC_DEN_SQ = 27'd100000000;

    localparam logic signed [SAMPLE_W-1:0] LOW_RESET = 16'sh7fff;

    localparam logic [MODE_W-1:0] MODE_WAVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPEC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEAK = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_SQRT,
        S_OUT
    } t_state;

endpackage

FILE: src/frps_if.sv
// valid/ready channel interfaces for samples in and frame results out
interface frps_in_if
    import frps_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;

    modport source (output valid, sample, frame_end, input ready);
    modport sink   (input valid, sample, frame_end, output ready);
endinterface

interface frps_out_if
    import frps_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [RMS_W-1:0]           rms_value;
    logic signed [SAMPLE_W-1:0] peak_low;
    logic [HIGH_W-1:0]          peak_high;
    logic [IDX_W-1:0]           peak_position;

    modport source (output valid, rms_value, peak_low, peak_high, peak_position, input ready);
    modport sink   (input valid, rms_value, peak_low, peak_high, peak_position, output ready);
endinterface

FILE: src/frame_rms_and_peak_statistics.sv
// frame rms and peak statistics: per-sample accumulation and a shared shift/add unit
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+-------------------------------------------------
//  i_in     | in  | valid / ready   | sample (s16), frame_end
//  o_out    | out | valid / ready   | rms_value (u22), peak_low (s16), peak_high (u15),
//           |     |                 | peak_position (u12)
//  i_cfg_*  | in  | wr_en strobe    | wr_data = rms_mode (u2)
//
//  samples go in one beat per cycle while idle; the beat with frame_end starts the rms job
//  rms job runs on one shared add/subtract unit, one bit per cycle:
//    waveform divide then root, spectrum multiply, divide then root, peak multiply then root, input not ready meanwhile
//  a finished result sits in the output register; the next frame streams in while it waits
//  reset is synchronous, active low; clears statistics, mode and the output valid
module frame_rms_and_peak_statistics
    import frps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    frps_in_if.sink           i_in,
    frps_out_if.source        o_out,
    input  logic              i_cfg_wr_en,
    input  logic [MODE_W-1:0] i_cfg_wr_data
);

    // control
    t_state              r_state, n_state;
    logic [MODE_W-1:0]   r_rms_mode;

    // frame statistics
    logic [SUM_W-1:0]           r_sum;
    logic [CNT_W-1:0]           r_count;
    logic signed [SAMPLE_W-1:0] r_low;
    logic [HIGH_W-1:0]          r_high;
    logic [IDX_W-1:0]           r_index;

    // shared unit operands
    logic [ACC_W-1:0]   r_acc,  n_acc;
    logic [REM_W-1:0]   r_rem,  n_rem;
    logic [QUO_W-1:0]   r_quo,  n_quo;
    logic [DVS_W-1:0]   r_dvs,  n_dvs;
    logic [STEP_W-1:0]  r_step, n_step;

    // output register
    logic                       r_out_valid;
    logic [RMS_W-1:0]           r_out_rms;
    logic signed [SAMPLE_W-1:0] r_out_low;
    logic [HIGH_W-1:0]          r_out_high;
    logic [IDX_W-1:0]           r_out_pos;

    logic                  w_in_beat;
    logic                  w_room;
    logic [SAMPLE_W-1:0]   w_raw;
    logic [SAMPLE_W-1:0]   w_mag;
    logic [2*SAMPLE_W-1:0] w_square;
    logic                  w_above;
    logic                  w_below;
    logic                  w_out_free;
    logic                  w_retire;
    logic                  w_last_step;
    logic                  w_peak_mode;
    logic                  w_spec_mode;

    logic [ACC_W-1:0]      w_alu_a;
    logic [ACC_W-1:0]      w_alu_b;
    logic                  w_alu_sub;
    logic [ACC_W:0]        w_alu;
    logic                  w_fits;
    logic [REM_W-1:0]      w_div_rem;
    logic [REM_W-1:0]      w_sqrt_rem;
    logic [ROOT_W+1:0]     w_sqrt_try;
    logic [QUO_W-1:0]      w_quo_shift;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_beat   = i_in.valid & i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_retire    = (r_state == S_OUT) && w_out_free;
    assign w_last_step = (r_step == '0);
    assign w_peak_mode = (r_rms_mode == MODE_PEAK);
    assign w_spec_mode = (r_rms_mode == MODE_SPEC);

    // ---------------------------------------------------------------
    // per-sample accumulation, one beat per cycle while idle
    // ---------------------------------------------------------------
    // samples past the frame limit are dropped but still may end the frame
    assign w_room   = (r_count < CNT_W'(MAX_FRAME));
    assign w_raw    = i_in.sample;
    assign w_mag    = w_raw[SAMPLE_W-1] ? (~w_raw + 1'b1) : w_raw;
    assign w_square = w_mag * w_mag;
    assign w_above  = !w_raw[SAMPLE_W-1] && (w_raw[HIGH_W-1:0] > r_high);
    assign w_below  = (i_in.sample < r_low);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_retire) begin
            r_sum   <= '0;
            r_count <= '0;
            r_low   <= LOW_RESET;
            r_high  <= '0;
            r_index <= '0;
        end else if (w_in_beat && w_room) begin
            r_sum   <= r_sum + SUM_W'(w_square);
            r_count <= r_count + 1'b1;
            if (w_below) begin
                r_low <= i_in.sample;
            end
            // strict compare keeps the first occurrence of the maximum
            if (w_above) begin
                r_high  <= w_raw[HIGH_W-1:0];
                r_index <= r_count[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rms_mode <= MODE_WAVE;
        end else if (i_cfg_wr_en) begin
            r_rms_mode <= i_cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------
    // shared add/subtract unit
    //   multiply: acc = 2*acc + (bit ? dvs : 0), multiplier bits msb first from quo
    //   divide:   restoring, dividend bits shift out of the top of acc
    //   root:     digit by digit, two radicand bits per step from the top of acc
    // ---------------------------------------------------------------
    assign w_div_rem   = {r_rem[REM_W-2:0], r_acc[ACC_W-1]};
    assign w_sqrt_rem  = {r_rem[REM_W-3:0], r_acc[ACC_W-1 -: 2]};
    assign w_sqrt_try  = {r_quo[ROOT_W-1:0], 2'b01};

    always_comb begin
        w_alu_a   = '0;
        w_alu_b   = '0;
        w_alu_sub = 1'b0;
        case (r_state)
            S_MUL: begin
                w_alu_a = {r_acc[ACC_W-2:0], 1'b0};
                w_alu_b = r_quo[SUM_W-1] ? ACC_W'(r_dvs) : '0;
            end
            S_DIV: begin
                w_alu_a   = ACC_W'(w_div_rem);
                w_alu_b   = ACC_W'(r_dvs);
                w_alu_sub = 1'b1;
            end
            S_SQRT: begin
                w_alu_a   = ACC_W'(w_sqrt_rem);
                w_alu_b   = ACC_W'(w_sqrt_try);
                w_alu_sub = 1'b1;
            end
            default: begin
                w_alu_sub = 1'b0;
            end
        endcase
    end

    assign w_alu = {1'b0, w_alu_a} + {1'b0, (w_alu_sub ? ~w_alu_b : w_alu_b)}
                 + (ACC_W+1)'(w_alu_sub);
    // carry out of a subtract means no borrow: the trial value fits
    assign w_fits      = w_alu[ACC_W];
    assign w_quo_shift = {r_quo[QUO_W-2:0], w_fits};

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_beat && i_in.frame_end) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = (w_spec_mode || w_peak_mode) ? S_MUL : S_DIV;
            end
            S_MUL: begin
                if (w_last_step) begin
                    n_state = w_peak_mode ? S_SQRT : S_DIV;
                end
            end
            S_DIV: begin
                if (w_last_step) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (w_last_step) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: datapath updates
    // ---------------------------------------------------------------
    always_comb begin
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_step = r_step;
        case (r_state)
            S_LOAD: begin
                n_rem  = '0;
                case (r_rms_mode)
                    MODE_SPEC: begin
                        // sum * 8165^2, later divided by 10000^2
                        n_acc  = '0;
                        n_quo  = QUO_W'(r_sum);
                        n_dvs  = SPEC_NUM_SQ;
                        n_step = STEP_W'(MUL_STEPS - 1);
                    end
                    MODE_PEAK: begin
                        // high^2, halved before the root
                        n_acc  = '0;
                        n_quo  = QUO_W'(r_high);
                        n_dvs  = DVS_W'(r_high);
                        n_step = STEP_W'(MUL_STEPS - 1);
                    end
                    default: begin
                        // waveform, unused code too: sum / count
                        n_acc  = {r_sum, {(ACC_W-SUM_W){1'b0}}};
                        n_quo  = '0;
                        n_dvs  = DVS_W'(r_count);
                        n_step = STEP_W'(DIV_STEPS_WAVE - 1);
                    end
                endcase
            end
            S_MUL: begin
                n_acc  = w_alu[ACC_W-1:0];
                n_quo  = {r_quo[QUO_W-2:0], 1'b0};
                n_step = r_step - 1'b1;
                if (w_last_step) begin
                    n_quo = '0;
                    n_rem = '0;
                    if (w_peak_mode) begin
                        n_acc  = {1'b0, w_alu[QUO_W-1:1], {(ACC_W-QUO_W){1'b0}}};
                        n_step = STEP_W'(SQRT_STEPS - 1);
                    end else begin
                        n_dvs  = SPEC_DEN_SQ;
                        n_step = STEP_W'(DIV_STEPS_SPEC - 1);
                    end
                end
            end
            S_DIV: begin
                n_acc  = {r_acc[ACC_W-2:0], 1'b0};
                n_rem  = w_fits ? w_alu[REM_W-1:0] : w_div_rem;
                n_quo  = w_quo_shift;
                n_step = r_step - 1'b1;
                if (w_last_step) begin
                    // quotient becomes the radicand
                    n_acc  = {w_quo_shift, {(ACC_W-QUO_W){1'b0}}};
                    n_rem  = '0;
                    n_quo  = '0;
                    n_step = STEP_W'(SQRT_STEPS - 1);
                end
            end
            S_SQRT: begin
                n_acc  = {r_acc[ACC_W-3:0], 2'b00};
                n_rem  = w_fits ? w_alu[REM_W-1:0] : w_sqrt_rem;
                n_quo  = w_quo_shift;
                n_step = r_step - 1'b1;
            end
            default: begin
                n_step = r_step;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_retire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // the root of a 44-bit radicand is below 2^22, so it fits the 22-bit rms output without saturation
    always_ff @(posedge i_clk) begin
        if (w_retire) begin
            r_out_rms  <= r_quo[RMS_W-1:0];
            r_out_low  <= r_low;
            r_out_high <= r_high;
            r_out_pos  <= r_index;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.rms_value     = r_out_rms;
    assign o_out.peak_low      = r_out_low;
    assign o_out.peak_high     = r_out_high;
    assign o_out.peak_position = r_out_pos;

endmodule
